// ----- src/med_pkg.sv -----
// shared types for the modular division block
// sequencer state encoding and the control groups between top level and sequencer
// no dependencies
package med_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GCD,
    S_GDIV,
    S_DIVN,
    S_DIVD,
    S_SEL,
    S_EXT,
    S_EDIV,
    S_AMOD,
    S_MUL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } med_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } med_sts_t;

endpackage

// ----- src/med_step.sv -----
// shared add, compare and conditional subtract unit
// used for division steps, modular doubling and modular addition
// no dependencies
module med_step #(
  parameter int WIDTH = 16
) (
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic             dbl,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] r,
  output logic             ge
);

  logic [WIDTH:0] sum;
  logic [WIDTH:0] dif;

  always_comb begin
    if (dbl) begin
      sum = {x, 1'b0} + {1'b0, y};
    end else begin
      sum = {1'b0, x} + {1'b0, y};
    end
    dif = sum - {1'b0, d};
    ge  = (sum >= {1'b0, d});
    r   = ge ? dif[WIDTH-1:0] : sum[WIDTH-1:0];
  end

endmodule

// ----- src/med_ctrl.sv -----
// sequencer and datapath registers for gcd reduction, extended euclid and modular product
// depends on med_pkg and med_step
module med_ctrl #(
  parameter int WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  med_pkg::med_req_t     req,
  output med_pkg::med_sts_t     sts,
  input  logic [WIDTH-1:0]      dividend,
  input  logic [WIDTH-1:0]      divisor,
  input  logic [WIDTH-1:0]      modulus,
  output logic [WIDTH-1:0]      quotient,
  output logic                  found
);

  localparam int CW = $clog2(WIDTH);

  med_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             ph_r, ph_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] dq_r, dq_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] t0_r, t0_nxt;
  logic [WIDTH-1:0] t1_r, t1_nxt;
  logic             neg_r, neg_nxt;
  logic [WIDTH-1:0] num_r, num_nxt;
  logic [WIDTH-1:0] den_r, den_nxt;
  logic [WIDTH-1:0] mod_r, mod_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic             fnd_r, fnd_nxt;

  logic [WIDTH-1:0] st_x, st_y, st_d, st_r;
  logic             st_dbl, st_ge;
  logic [WIDTH-1:0] dq_sh;
  logic [WIDTH-1:0] horner;
  logic             last;

  med_step #(.WIDTH(WIDTH)) u_step (
    .x   (st_x),
    .y   (st_y),
    .dbl (st_dbl),
    .d   (st_d),
    .r   (st_r),
    .ge  (st_ge)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= med_pkg::S_IDLE;
      cnt_r   <= '0;
      ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    t0_r  <= t0_nxt;
    t1_r  <= t1_nxt;
    neg_r <= neg_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    mod_r <= mod_nxt;
    quo_r <= quo_nxt;
    fnd_r <= fnd_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ph_nxt    = ph_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    neg_nxt   = neg_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    mod_nxt   = mod_r;
    quo_nxt   = quo_r;
    fnd_nxt   = fnd_r;

    // default: one restoring division step
    st_x   = rem_r;
    st_y   = {{(WIDTH-1){1'b0}}, dq_r[WIDTH-1]};
    st_dbl = 1'b1;
    st_d   = b_r;

    dq_sh  = {dq_r[WIDTH-2:0], st_ge};
    horner = {acc_r[WIDTH-2:0], 1'b0} + (st_ge ? t1_r : '0);
    last   = (cnt_r == '0);

    case (state_r)
      med_pkg::S_IDLE: begin
        if (req.start) begin
          num_nxt   = dividend;
          den_nxt   = divisor;
          mod_nxt   = modulus;
          a_nxt     = dividend;
          b_nxt     = divisor;
          state_nxt = med_pkg::S_GCD;
        end
      end
      med_pkg::S_GCD: begin
        rem_nxt = '0;
        cnt_nxt = CW'(WIDTH - 1);
        if (b_r == '0) begin
          if (a_r == '0) begin
            quo_nxt   = '0;
            fnd_nxt   = 1'b0;
            state_nxt = med_pkg::S_FIN;
          end else begin
            dq_nxt    = num_r;
            state_nxt = med_pkg::S_DIVN;
          end
        end else begin
          dq_nxt    = a_r;
          state_nxt = med_pkg::S_GDIV;
        end
      end
      med_pkg::S_GDIV: begin
        rem_nxt = st_r;
        dq_nxt  = dq_sh;
        cnt_nxt = cnt_r - 1'b1;
        if (last) begin
          a_nxt     = b_r;
          b_nxt     = st_r;
          state_nxt = med_pkg::S_GCD;
        end
      end
      med_pkg::S_DIVN: begin
        st_d    = a_r;
        rem_nxt = st_r;
        dq_nxt  = dq_sh;
        cnt_nxt = cnt_r - 1'b1;
        if (last) begin
          num_nxt   = dq_sh;
          dq_nxt    = den_r;
          rem_nxt   = '0;
          cnt_nxt   = CW'(WIDTH - 1);
          state_nxt = med_pkg::S_DIVD;
        end
      end
      med_pkg::S_DIVD: begin
        st_d    = a_r;
        rem_nxt = st_r;
        dq_nxt  = dq_sh;
        cnt_nxt = cnt_r - 1'b1;
        if (last) begin
          den_nxt   = dq_sh;
          state_nxt = med_pkg::S_SEL;
        end
      end
      med_pkg::S_SEL: begin
        if (mod_r == '0) begin
          fnd_nxt   = (den_r == WIDTH'(1));
          quo_nxt   = (den_r == WIDTH'(1)) ? num_r : '0;
          state_nxt = med_pkg::S_FIN;
        end else begin
          a_nxt     = den_r;
          b_nxt     = mod_r;
          t0_nxt    = WIDTH'(1);
          t1_nxt    = '0;
          neg_nxt   = 1'b0;
          state_nxt = med_pkg::S_EXT;
        end
      end
      med_pkg::S_EXT: begin
        rem_nxt = '0;
        acc_nxt = '0;
        cnt_nxt = CW'(WIDTH - 1);
        if (b_r == '0) begin
          if (a_r != WIDTH'(1)) begin
            quo_nxt   = '0;
            fnd_nxt   = 1'b0;
            state_nxt = med_pkg::S_FIN;
          end else begin
            // coefficient sign alternates with the round count
            if (neg_r && (t0_r != '0)) begin
              t0_nxt = mod_r - t0_r;
            end
            dq_nxt    = num_r;
            state_nxt = med_pkg::S_AMOD;
          end
        end else begin
          dq_nxt    = a_r;
          state_nxt = med_pkg::S_EDIV;
        end
      end
      med_pkg::S_EDIV: begin
        rem_nxt = st_r;
        dq_nxt  = dq_sh;
        acc_nxt = horner;
        cnt_nxt = cnt_r - 1'b1;
        if (last) begin
          a_nxt     = b_r;
          b_nxt     = st_r;
          t0_nxt    = t1_r;
          t1_nxt    = t0_r + horner;
          neg_nxt   = ~neg_r;
          state_nxt = med_pkg::S_EXT;
        end
      end
      med_pkg::S_AMOD: begin
        st_d    = mod_r;
        rem_nxt = st_r;
        dq_nxt  = dq_sh;
        cnt_nxt = cnt_r - 1'b1;
        if (last) begin
          a_nxt     = st_r;
          acc_nxt   = '0;
          dq_nxt    = t0_r;
          ph_nxt    = 1'b0;
          cnt_nxt   = CW'(WIDTH - 1);
          state_nxt = med_pkg::S_MUL;
        end
      end
      med_pkg::S_MUL: begin
        st_x = acc_r;
        st_d = mod_r;
        if (!ph_r) begin
          st_y    = '0;
          st_dbl  = 1'b1;
          acc_nxt = st_r;
          ph_nxt  = 1'b1;
        end else begin
          st_y    = dq_r[WIDTH-1] ? a_r : '0;
          st_dbl  = 1'b0;
          acc_nxt = st_r;
          dq_nxt  = {dq_r[WIDTH-2:0], 1'b0};
          ph_nxt  = 1'b0;
          cnt_nxt = cnt_r - 1'b1;
          if (last) begin
            quo_nxt   = st_r;
            fnd_nxt   = 1'b1;
            state_nxt = med_pkg::S_FIN;
          end
        end
      end
      med_pkg::S_FIN: begin
        if (req.ack) begin
          state_nxt = med_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = med_pkg::S_IDLE;
      end
    endcase
  end

  assign sts.idle = (state_r == med_pkg::S_IDLE);
  assign sts.done = (state_r == med_pkg::S_FIN);
  assign quotient = quo_r;
  assign found    = fnd_r;

endmodule

// ----- src/modular_division_ext_euclid_unit.sv -----
// modular division top level: stream ports, result register, sequencer instance
// depends on med_pkg, med_ctrl, med_step
//
// channel  direction  tdata (low bit up)                 tuser
// in_      slave      dividend, divisor, modulus         -
// out_     master     quotient                           found
//
// on the full path the sequencer runs the plain euclid loop, the divisions by the gcd, the
// extended euclid loop, the reduction and the modular product; in_tready rises in the cycle
// in which out_tvalid rises; both operands zero or modulus zero end sooner
// division, modular doubling and modular addition steps share one add, compare, subtract unit
// in_tready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next transfer may start while out_tready is low
// reset is synchronous and active low and clears the sequencer and out_tvalid
module modular_division_ext_euclid_unit #(
  parameter int WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // dividend, divisor, modulus
  input  logic [((3*WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // quotient
  output logic [((WIDTH+7)/8)*8-1:0]       out_tdata,
  // found
  output logic                             out_tuser
);

  localparam int OUT_W = ((WIDTH+7)/8)*8;

  med_pkg::med_req_t req;
  med_pkg::med_sts_t sts;
  logic [WIDTH-1:0]  quo;
  logic              fnd;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [WIDTH-1:0]  out_quo_r, out_quo_nxt;
  logic              out_fnd_r, out_fnd_nxt;

  med_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .sts      (sts),
    .dividend (in_tdata[WIDTH-1:0]),
    .divisor  (in_tdata[2*WIDTH-1:WIDTH]),
    .modulus  (in_tdata[3*WIDTH-1:2*WIDTH]),
    .quotient (quo),
    .found    (fnd)
  );

  assign in_tready = sts.idle;

  always_comb begin
    req.start      = in_tvalid && sts.idle;
    req.ack        = sts.done && (!out_tvalid_r || out_tready);
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_quo_nxt    = out_quo_r;
    out_fnd_nxt    = out_fnd_r;
    if (req.ack) begin
      out_tvalid_nxt = 1'b1;
      out_quo_nxt    = quo;
      out_fnd_nxt    = fnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_quo_r <= out_quo_nxt;
    out_fnd_r <= out_fnd_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'(out_quo_r);
  assign out_tuser  = out_fnd_r;

endmodule

// ----- sim/modular_division_ext_euclid_unit_test.sv -----
// self-checking bench for modular_division_ext_euclid_unit: a directed table, then random
// operands, with results compared against typed rows or a predictor of the modular division
// depends on the modular_division_ext_euclid_unit rtl only
module modular_division_ext_euclid_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 16;
  localparam int RANDOM_ITEMS = 1825;
  localparam int HOLD_CYCLES = 2500;
  localparam int DRAIN_CYCLES = 1500;
  localparam longint CYCLE_LIMIT = 8000000;

  typedef struct packed {
    logic [W-1:0] quotient;
    logic         found;
  } division_result_t;

  typedef struct {
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic [W-1:0] modulus;
    bit           typed;
    logic [W-1:0] quotient;
    logic         found;
  } directed_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [3*W-1:0]      in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [W-1:0]        out_tdata;
  logic                out_tuser;

  division_result_t    pending_quotients[$];
  int unsigned         error_count = 0;
  int unsigned         results_seen = 0;
  int unsigned         found_count = 0;
  int unsigned         items_sent = 0;
  int unsigned         no_wrap_items = 0;
  longint              cycle_count = 0;

  directed_row_t directed_rows [24] = '{
    '{16'd0,     16'd0,     16'd0,     1'b1, 16'd0,     1'b0},
    '{16'd0,     16'd0,     16'd7,     1'b1, 16'd0,     1'b0},
    '{16'd0,     16'd5,     16'd0,     1'b1, 16'd0,     1'b1},
    '{16'd0,     16'hFFFF,  16'hFFFF,  1'b1, 16'd0,     1'b1},
    '{16'd5,     16'd0,     16'd1,     1'b1, 16'd0,     1'b1},
    '{16'd5,     16'd0,     16'd7,     1'b1, 16'd0,     1'b0},
    '{16'd5,     16'd0,     16'd0,     1'b1, 16'd0,     1'b0},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, 16'd1,     1'b1},
    '{16'hFFFF,  16'd1,     16'd0,     1'b1, 16'hFFFF,  1'b1},
    '{16'hFFFF,  16'd2,     16'd0,     1'b1, 16'd0,     1'b0},
    '{16'd12,    16'd4,     16'd0,     1'b1, 16'd3,     1'b1},
    '{16'd7,     16'd3,     16'd1,     1'b1, 16'd0,     1'b1},
    '{16'hFFFF,  16'hFFFF,  16'd0,     1'b1, 16'd1,     1'b1},
    '{16'd1,     16'd2,     16'd4,     1'b1, 16'd0,     1'b0},
    '{16'd1,     16'd1,     16'hFFFF,  1'b1, 16'd1,     1'b1},
    '{16'h8000,  16'h8000,  16'h8000,  1'b1, 16'd1,     1'b1},
    '{16'd3,     16'd2,     16'd5,     1'b0, 16'd0,     1'b0},
    '{16'd1,     16'hFFFF,  16'hFFFE,  1'b0, 16'd0,     1'b0},
    '{16'd40000, 16'd12345, 16'd65521, 1'b0, 16'd0,     1'b0},
    '{16'hFFFE,  16'hFFFD,  16'hFFFF,  1'b0, 16'd0,     1'b0},
    '{16'hAAAA,  16'h5555,  16'hFFFF,  1'b0, 16'd0,     1'b0},
    '{16'h5555,  16'hAAAA,  16'h8001,  1'b0, 16'd0,     1'b0},
    '{16'd6,     16'd4,     16'd3,     1'b0, 16'd0,     1'b0},
    '{16'd10,    16'd4,     16'd6,     1'b0, 16'd0,     1'b0}
  };

  modular_division_ext_euclid_unit #(.WIDTH(W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic division_result_t predict_division(input logic [W-1:0] dvd,
                                                        input logic [W-1:0] dvs,
                                                        input logic [W-1:0] md);
    longint a, b, t, g, num, den, m;
    longint r_prev, r_cur, s_prev, s_cur, qq, prod;
    division_result_t res;
    res = '0;
    a = longint'(dvd);
    b = longint'(dvs);
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    g = a;
    if (g != 0) begin
      num = longint'(dvd) / g;
      den = longint'(dvs) / g;
      m = longint'(md);
      if (m == 0) begin
        if (den == 1) begin
          res.quotient = num[W-1:0];
          res.found = 1'b1;
        end
      end else begin
        r_prev = den;
        r_cur = m;
        s_prev = 1;
        s_cur = 0;
        while (r_cur != 0) begin
          qq = r_prev / r_cur;
          t = r_prev - qq * r_cur;
          r_prev = r_cur;
          r_cur = t;
          t = s_prev - qq * s_cur;
          s_prev = s_cur;
          s_cur = t;
        end
        if (r_prev == 1) begin
          s_prev = s_prev % m;
          if (s_prev < 0) s_prev = s_prev + m;
          prod = (s_prev * (num % m)) % m;
          res.quotient = prod[W-1:0];
          res.found = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [W-1:0] pick_extreme();
    logic [W-1:0] v;
    case ($urandom_range(0, 6))
      0: v = '0;
      1: v = 16'd1;
      2: v = 16'd2;
      3: v = 16'hFFFF;
      4: v = 16'hFFFE;
      5: v = 16'h8000;
      default: v = W'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  function automatic logic [3*W-1:0] draw_operands();
    logic [W-1:0] a, b, m;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    a = W'($urandom_range(0, 65535));
    b = W'($urandom_range(0, 65535));
    m = W'($urandom_range(0, 65535));
    case (kind)
      4, 5: begin
        a = W'($urandom_range(0, 31));
        b = W'($urandom_range(0, 31));
        m = W'($urandom_range(0, 31));
      end
      6: begin
        b = W'($urandom_range(1, 255));
        a = W'(int'(b) * $urandom_range(0, 65535 / int'(b)));
        m = '0;
      end
      7: begin
        case ($urandom_range(0, 2))
          0: a = '0;
          1: b = '0;
          default: m = '0;
        endcase
      end
      8: begin
        case ($urandom_range(0, 5))
          0: m = 16'd65521;
          1: m = 16'd65519;
          2: m = 16'd257;
          3: m = 16'd251;
          4: m = 16'd3;
          default: m = 16'd2;
        endcase
      end
      9: begin
        a = pick_extreme();
        b = pick_extreme();
        m = pick_extreme();
      end
      default: ;
    endcase
    return {m, b, a};
  endfunction

  task automatic offer_operands(input logic [3*W-1:0] word, input int unsigned gap,
                                input bit typed, input division_result_t typed_result);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    if (typed)
      pending_quotients.push_back(typed_result);
    else
      pending_quotients.push_back(predict_division(word[W-1:0], word[2*W-1:W],
                                                   word[3*W-1:2*W]));
    items_sent++;
    if (word[3*W-1:2*W] == '0) no_wrap_items++;
  endtask

  function automatic int unsigned sender_gap(input int unsigned idx);
    return ((idx / 128) % 4 == 1) ? 0 : $urandom_range(0, 11);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_quotients.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    division_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser) found_count++;
      if (pending_quotients.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: quotient %0d found %0b", out_tdata, out_tuser);
      end else begin
        want = pending_quotients.pop_front();
        if (out_tdata !== want.quotient || out_tuser !== want.found) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch at result %0d: expected quotient %0d found %0b, got %0d %0b",
                     results_seen, want.quotient, want.found, out_tdata, out_tuser);
        end
      end
    end
  end

  // receiver with random stalls and two long hold-offs
  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 20 || taken == 1000)
        stall = HOLD_CYCLES;
      else if ((taken / 100) % 4 == 2)
        stall = 0;
      else
        stall = $urandom_range(0, 11);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin
    int unsigned idx;
    division_result_t typed_result;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (idx = 0; idx < $size(directed_rows); idx++) begin
      typed_result.quotient = directed_rows[idx].quotient;
      typed_result.found = directed_rows[idx].found;
      offer_operands({directed_rows[idx].modulus, directed_rows[idx].divisor,
                      directed_rows[idx].dividend},
                     sender_gap(idx), directed_rows[idx].typed, typed_result);
    end

    typed_result = '0;
    for (idx = 0; idx < RANDOM_ITEMS; idx++)
      offer_operands(draw_operands(), sender_gap(idx), 1'b0, typed_result);
    in_tvalid <= 1'b0;

    while (pending_quotients.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d operand transfers (%0d without wrap), %0d results, %0d found",
             items_sent, no_wrap_items, results_seen, found_count);
    $display("%0d mismatching or unexpected results", error_count);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
